### sv/lsfd_pkg.sv
// shared types and constants for the lsb stego frame decoder
// no dependencies; imported by lsb_stego_frame_decoder_unit
`default_nettype none

package lsfd_pkg;

    localparam int MAX_MAGIC_BYTES = 8;
    localparam int SIZE_FIELD_BITS = 32;

    localparam int HDR_W      = 16;
    localparam int MLEN_W     = 4;
    localparam int MWORD_W    = 8 * MAX_MAGIC_BYTES;
    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int VALUE_W    = 32;
    localparam int BIT_CNT_W  = $clog2(SIZE_FIELD_BITS);

    localparam logic [HDR_W-1:0]   HDR_RESET   = HDR_W'(54);
    localparam logic [MLEN_W-1:0]  MLEN_RESET  = MLEN_W'(2);
    localparam logic [MWORD_W-1:0] MWORD_RESET = MWORD_W'(8998);
    localparam logic [MLEN_W-1:0]  MLEN_MAX    = MLEN_W'(MAX_MAGIC_BYTES);

    localparam logic [BIT_CNT_W:0] NEED_SIZE = (BIT_CNT_W + 1)'(SIZE_FIELD_BITS);
    localparam logic [BIT_CNT_W:0] NEED_BYTE = (BIT_CNT_W + 1)'(8);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_MAGIC,
        PH_EXTLEN,
        PH_EXT,
        PH_FSIZE,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_EXTLEN   = 3'd0,
        KIND_EXTBYTE  = 3'd1,
        KIND_FSIZE    = 3'd2,
        KIND_DATA     = 3'd3,
        KIND_MISMATCH = 3'd4
    } t_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HEADER_BYTES = 2'd0,
        CFG_MAGIC_LENGTH = 2'd1,
        CFG_MAGIC_WORD   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_kind              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

### sv/lsb_stego_frame_decoder_unit.sv
// lsb stego frame decoder: parses hidden fields from image byte lsbs
// depends on lsfd_pkg; output register plus one skid stage on the result side
//
// One image byte is taken per cycle while the skid stage is empty; each
// accepted beat updates the parser and yields at most one result beat,
// loaded into the output register or the skid register. The first
// header_bytes bytes of an image are skipped, then the bit 0 of every byte is
// shifted in msb first: magic bytes (compared with magic_word, mismatch ends
// the frame with kind 4), extension length, extension bytes, file size and
// data bytes. tuser on the input marks the first byte of a new image. A
// result register and a skid register keep input flowing while the output side
// stalls, until a second result beat is waiting; s_axis_tready depends only on
// the skid stage. Configuration writes take effect on the next beat.
`default_nettype none

module lsb_stego_frame_decoder_unit
    import lsfd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // image_byte
    input  wire logic                  s_axis_tuser,   // start_of_image
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [VALUE_W-1:0]         m_axis_tdata,   // value
    output logic [2:0]                 m_axis_tuser,   // kind
    output logic                       m_axis_tlast    // last
);

    logic [HDR_W-1:0]           r_header_bytes;
    logic [MLEN_W-1:0]          r_magic_len;
    logic [MWORD_W-1:0]         r_magic_word;

    t_phase                     r_phase, n_phase;
    logic [HDR_W-1:0]           r_hcnt, n_hcnt;
    logic [BIT_CNT_W-1:0]       r_bits, n_bits;
    logic [SIZE_FIELD_BITS-1:0] r_acc, n_acc;
    logic [SIZE_FIELD_BITS-1:0] r_rem, n_rem;
    logic [MLEN_W-1:0]          r_midx, n_midx;

    t_result                    r_out, r_skid, res;
    logic                       r_out_valid, r_skid_valid;

    // view of the state after an optional restart
    t_phase                     c_phase, w_phase;
    logic [HDR_W-1:0]           c_hcnt;
    logic [BIT_CNT_W-1:0]       c_bits, w_bits;
    logic [SIZE_FIELD_BITS-1:0] c_acc, w_acc, acc_new, rem_dec;
    logic [SIZE_FIELD_BITS-1:0] c_rem;
    logic [MLEN_W-1:0]          c_midx, w_midx, midx_inc, mlen, msel;
    logic [BIT_CNT_W:0]         cnt_new, need;
    logic [7:0]                 expected, rx_byte;
    logic                       accept, push, pop, go;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;

    assign mlen = (r_magic_len > MLEN_MAX) ? MLEN_MAX : r_magic_len;

    always_comb begin
        c_phase  = s_axis_tuser ? PH_HEADER : r_phase;
        c_hcnt   = s_axis_tuser ? '0 : r_hcnt;
        c_bits   = s_axis_tuser ? '0 : r_bits;
        c_acc    = s_axis_tuser ? '0 : r_acc;
        c_rem    = s_axis_tuser ? '0 : r_rem;
        c_midx   = s_axis_tuser ? '0 : r_midx;

        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_bits   = r_bits;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_midx   = r_midx;
        push     = 1'b0;
        res      = '{kind: KIND_EXTLEN, value: '0, last: 1'b0};
        go       = 1'b0;
        w_phase  = c_phase;
        w_bits   = c_bits;
        w_acc    = c_acc;
        w_midx   = c_midx;
        acc_new  = '0;
        cnt_new  = '0;
        need     = NEED_BYTE;
        rx_byte  = '0;
        midx_inc = '0;
        msel     = '0;
        expected = '0;
        rem_dec  = c_rem - SIZE_FIELD_BITS'(1);

        if (accept) begin
            n_phase = c_phase;
            n_hcnt  = c_hcnt;
            n_bits  = c_bits;
            n_acc   = c_acc;
            n_rem   = c_rem;
            n_midx  = c_midx;
            if (c_phase == PH_HEADER) begin
                if (c_hcnt < r_header_bytes) begin
                    n_hcnt = c_hcnt + HDR_W'(1);
                end else begin
                    go      = 1'b1;
                    w_phase = (mlen == '0) ? PH_EXTLEN : PH_MAGIC;
                    w_midx  = '0;
                    w_bits  = '0;
                    w_acc   = '0;
                end
            end else if (c_phase != PH_DONE) begin
                go = 1'b1;
            end
        end

        if (go) begin
            acc_new  = {w_acc[SIZE_FIELD_BITS-2:0], s_axis_tdata[0]};
            cnt_new  = {1'b0, w_bits} + (BIT_CNT_W + 1)'(1);
            need     = (w_phase == PH_EXTLEN || w_phase == PH_FSIZE) ? NEED_SIZE : NEED_BYTE;
            rx_byte  = acc_new[7:0];
            midx_inc = w_midx + MLEN_W'(1);
            msel     = mlen - MLEN_W'(1) - w_midx;
            expected = 8'(r_magic_word >> {msel, 3'b000});
            n_phase  = w_phase;
            n_midx   = w_midx;
            if (cnt_new < need) begin
                n_bits = BIT_CNT_W'(cnt_new);
                n_acc  = acc_new;
            end else begin
                n_bits = '0;
                n_acc  = '0;
                unique case (w_phase)
                    PH_MAGIC: begin
                        if (w_midx < mlen && expected != rx_byte) begin
                            n_phase = PH_DONE;
                            push    = 1'b1;
                            res     = '{kind: KIND_MISMATCH, value: '0, last: 1'b1};
                        end else begin
                            n_midx = midx_inc;
                            if (midx_inc >= mlen) begin
                                n_phase = PH_EXTLEN;
                            end
                        end
                    end
                    PH_EXTLEN: begin
                        n_rem   = acc_new;
                        n_phase = (acc_new != '0) ? PH_EXT : PH_FSIZE;
                        push    = 1'b1;
                        res     = '{kind: KIND_EXTLEN, value: VALUE_W'(acc_new), last: 1'b0};
                    end
                    PH_EXT: begin
                        n_rem = rem_dec;
                        if (rem_dec == '0) begin
                            n_phase = PH_FSIZE;
                        end
                        push = 1'b1;
                        res  = '{kind: KIND_EXTBYTE, value: VALUE_W'(rx_byte), last: 1'b0};
                    end
                    PH_FSIZE: begin
                        n_rem   = acc_new;
                        n_phase = (acc_new != '0) ? PH_DATA : PH_DONE;
                        push    = 1'b1;
                        res     = '{kind: KIND_FSIZE, value: VALUE_W'(acc_new),
                                    last: (acc_new == '0)};
                    end
                    PH_DATA: begin
                        n_rem   = rem_dec;
                        n_phase = (rem_dec == '0) ? PH_DONE : PH_DATA;
                        push    = 1'b1;
                        res     = '{kind: KIND_DATA, value: VALUE_W'(rx_byte),
                                    last: (rem_dec == '0)};
                    end
                    default: begin
                        n_phase = PH_DONE;
                    end
                endcase
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= HDR_RESET;
            r_magic_len    <= MLEN_RESET;
            r_magic_word   <= MWORD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HEADER_BYTES: r_header_bytes <= i_cfg_wdata[HDR_W-1:0];
                CFG_MAGIC_LENGTH: r_magic_len    <= i_cfg_wdata[MLEN_W-1:0];
                CFG_MAGIC_WORD:   r_magic_word   <= i_cfg_wdata[MWORD_W-1:0];
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hcnt  <= '0;
            r_bits  <= '0;
            r_acc   <= '0;
            r_rem   <= '0;
            r_midx  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_bits  <= n_bits;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_midx  <= n_midx;
        end
    end

    // result register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid  <= r_skid_valid || push;
            r_skid_valid <= 1'b0;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (push) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.value;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    // skid beat only exists behind a held output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage valid without output beat");

    // a finished frame stays silent until a new image starts
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_DONE && !s_axis_tuser) |-> !push)
        else $error("result produced after end of frame");

    // a stalled output with a full skid stage must block input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !m_axis_tready) |=> r_skid_valid && r_out_valid)
        else $error("buffered beat lost under back pressure");

    a_midx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_midx <= MLEN_MAX)
        else $error("magic index beyond maximum magic length");

endmodule

`default_nettype wire

### tb/lsb_stego_frame_decoder_unit_tb.sv
// self-checking testbench for lsb_stego_frame_decoder_unit
// depends on lsfd_pkg; drives image byte beats, predicts fields, checks every result beat
// directed frames from a table first, then random frames with random idling on both streams

module lsb_stego_frame_decoder_unit_tb;
    import lsfd_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_BEATS  = 450;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int N_CASES       = 12;
    localparam int NO_MID        = -1;
    localparam int NO_BAD        = -1;

    localparam t_result FSIZE_ZERO_END = '{KIND_FSIZE, 32'd0, 1'b1};
    localparam t_result MISMATCH_END   = '{KIND_MISMATCH, 32'd0, 1'b1};
    localparam t_result NO_RESULT      = '{KIND_EXTLEN, 32'd0, 1'b0};

    typedef struct {
        logic [15:0] hdr;
        logic [3:0]  mlen;
        logic [63:0] mword;
        logic        sou;
        int          bad_at;
        logic [31:0] ext_len;
        logic [31:0] fsize;
        int          cap;
        int          mid_pos;
        t_cfg_idx    mid_idx;
        logic [63:0] mid_val;
        bit          has_exp;
        t_result     exp_res;
    } t_case;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // image_byte
    logic                  s_axis_tuser;   // start_of_image
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [VALUE_W-1:0]    m_axis_tdata;   // value
    logic [2:0]            m_axis_tuser;   // kind
    logic                  m_axis_tlast;

    // decoder copy: configuration and parser state
    logic [15:0] cfg_hdr;
    logic [3:0]  cfg_mlen;
    logic [63:0] cfg_mword;
    t_phase      ph;
    logic [15:0] hdr_cnt;
    int          bit_cnt;
    logic [31:0] acc;
    logic [31:0] remaining;
    logic [3:0]  mag_idx;

    t_result pending_results[$];
    t_result last_seen;
    t_result head;
    int      n_errors = 0;
    int      idle_cycles = 0;
    int      beats_fed = 0;
    bit      src_burst = 1'b0;
    t_case   cases[N_CASES];

    lsb_stego_frame_decoder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int magic_bytes_used();
        return (cfg_mlen > MLEN_MAX) ? MAX_MAGIC_BYTES : int'(cfg_mlen);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // advances the decoder copy by one image byte, returns 1 when a result beat is due
    function automatic bit decode_beat(input logic [7:0] b, input logic sou, output t_result r);
        logic [31:0] val;
        logic [7:0]  want8;
        int          need;
        int          len;
        r = NO_RESULT;
        if (sou) begin
            ph = PH_HEADER;
            hdr_cnt = '0;
            bit_cnt = 0;
            acc = '0;
            remaining = '0;
            mag_idx = '0;
        end
        if (ph == PH_DONE) return 1'b0;
        if (ph == PH_HEADER) begin
            if (hdr_cnt < cfg_hdr) begin
                hdr_cnt = hdr_cnt + 16'd1;
                return 1'b0;
            end
            ph = (magic_bytes_used() == 0) ? PH_EXTLEN : PH_MAGIC;
            mag_idx = '0;
            bit_cnt = 0;
            acc = '0;
        end
        acc = {acc[30:0], b[0]};
        bit_cnt++;
        need = (ph == PH_EXTLEN || ph == PH_FSIZE) ? SIZE_FIELD_BITS : 8;
        if (bit_cnt < need) return 1'b0;
        val = acc;
        bit_cnt = 0;
        acc = '0;
        case (ph)
            PH_MAGIC: begin
                len = magic_bytes_used();
                want8 = val[7:0];
                if (int'(mag_idx) < len)
                    want8 = 8'(cfg_mword >> ((len - 1 - int'(mag_idx)) * 8));
                if (want8 != val[7:0]) begin
                    ph = PH_DONE;
                    r = MISMATCH_END;
                    return 1'b1;
                end
                mag_idx = mag_idx + 4'd1;
                if (int'(mag_idx) >= len) ph = PH_EXTLEN;
                return 1'b0;
            end
            PH_EXTLEN: begin
                remaining = val;
                ph = (val != 0) ? PH_EXT : PH_FSIZE;
                r = '{KIND_EXTLEN, val, 1'b0};
                return 1'b1;
            end
            PH_EXT: begin
                remaining = remaining - 32'd1;
                if (remaining == 0) ph = PH_FSIZE;
                r = '{KIND_EXTBYTE, {24'd0, val[7:0]}, 1'b0};
                return 1'b1;
            end
            PH_FSIZE: begin
                remaining = val;
                ph = (val != 0) ? PH_DATA : PH_DONE;
                r = '{KIND_FSIZE, val, val == 0};
                return 1'b1;
            end
            PH_DATA: begin
                remaining = remaining - 32'd1;
                r = '{KIND_DATA, {24'd0, val[7:0]}, remaining == 0};
                if (remaining == 0) ph = PH_DONE;
                return 1'b1;
            end
            default: begin
                ph = PH_DONE;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic sou);
        int      gap;
        t_result r;
        gap = src_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sou;
        do @(posedge i_clk); while (!s_axis_tready);
        if (decode_beat(b, sou, r)) pending_results.push_back(r);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HEADER_BYTES: cfg_hdr = v[15:0];
            CFG_MAGIC_LENGTH: cfg_mlen = v[3:0];
            CFG_MAGIC_WORD:   cfg_mword = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // builds a frame beat by beat from where the parser stands, so it stays well formed
    // after restarts and mid-frame register writes
    task automatic run_frame(input logic sou, input int bad_at, input logic [31:0] ext_len,
                             input logic [31:0] fsize, input int cap, input int mid_pos,
                             input t_cfg_idx mid_idx, input logic [63:0] mid_val);
        int          sent;
        int          body;
        int          flip;
        int          vbits;
        int          vidx;
        t_phase      vph;
        logic [15:0] vhc;
        logic [7:0]  b;
        logic [7:0]  mb;
        bit          first;
        flip  = $urandom_range(0, 7);
        first = 1'b1;
        sent  = 0;
        body  = 0;
        forever begin
            if (sent == mid_pos) begin
                settle();
                write_reg(mid_idx, mid_val);
            end
            vph   = ph;
            vhc   = hdr_cnt;
            vbits = bit_cnt;
            vidx  = int'(mag_idx);
            if (first && sou) begin
                vph = PH_HEADER;
                vhc = '0;
            end
            if (vph == PH_DONE) break;
            if (vph == PH_HEADER && vhc >= cfg_hdr) begin
                vph   = (magic_bytes_used() == 0) ? PH_EXTLEN : PH_MAGIC;
                vbits = 0;
                vidx  = 0;
            end
            b = 8'($urandom);
            case (vph)
                PH_MAGIC: begin
                    if (vidx < magic_bytes_used()) begin
                        mb = 8'(cfg_mword >> ((magic_bytes_used() - 1 - vidx) * 8));
                        b[0] = mb[7 - vbits] ^ (vidx == bad_at && vbits == flip);
                    end
                end
                PH_EXTLEN: b[0] = ext_len[31 - vbits];
                PH_FSIZE:  b[0] = fsize[31 - vbits];
                PH_EXT, PH_DATA: begin
                    if (body >= cap * 8) break;
                    body++;
                end
                default: ;
            endcase
            put_byte(b, first ? sou : 1'b0);
            first = 1'b0;
            sent++;
        end
        beats_fed += sent;
        if (ph == PH_DONE) repeat ($urandom_range(0, 3)) put_byte(8'($urandom), 1'b0);
    endtask

    // result side: compare each beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            last_seen = '{t_kind'(m_axis_tuser), m_axis_tdata, m_axis_tlast};
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: kind %0d value %h last %0d", $time,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end else begin
                head = pending_results.pop_front();
                if (head.kind !== last_seen.kind || head.value !== last_seen.value ||
                    head.last !== last_seen.last) begin
                    n_errors++;
                    $display("%0t: result mismatch: expected kind %0d value %h last %0d,",
                             $time, head.kind, head.value, head.last,
                             " got kind %0d value %h last %0d",
                             m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // receiver backpressure
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(20, 150)) @(posedge i_clk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("lsb_stego_frame_decoder_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] ext_len;
        logic [31:0] fsize;
        int          bad_at;
        int          mid_pos;
        t_cfg_idx    mid_idx;
        logic [63:0] mid_val;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        last_seen = NO_RESULT;
        cfg_hdr   = HDR_RESET;
        cfg_mlen  = MLEN_RESET;
        cfg_mword = MWORD_RESET;
        ph        = PH_HEADER;
        hdr_cnt   = '0;
        bit_cnt   = 0;
        acc       = '0;
        remaining = '0;
        mag_idx   = '0;

        // hdr, mlen, mword, sou, bad, ext_len, fsize, cap, mid_pos, mid reg, mid value, typed end
        // first frame after reset: reset values, no start flag
        cases[0]  = '{16'd54, 4'd2, 64'd8998, 1'b0, NO_BAD, 32'd1, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, FSIZE_ZERO_END};
        // no header, no magic, zero extension and zero file size
        cases[1]  = '{16'd0, 4'd0, 64'd0, 1'b1, NO_BAD, 32'd0, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, FSIZE_ZERO_END};
        cases[2]  = '{16'd1, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_BAD, 32'd2, 32'd3, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b0, NO_RESULT};
        // wrong first magic byte
        cases[3]  = '{16'd2, 4'd8, 64'd0, 1'b1, 0, 32'd0, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, MISMATCH_END};
        // magic length above the maximum, wrong last magic byte
        cases[4]  = '{16'd0, 4'd15, 64'hA5C3_0F96_5AE1_7B28, 1'b1, 7, 32'd0, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, MISMATCH_END};
        cases[5]  = '{16'd100, 4'd1, 64'h7E, 1'b1, NO_BAD, 32'd0, 32'd1, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b0, NO_RESULT};
        // largest sizes, cut short by the next start of image
        cases[6]  = '{16'd3, 4'd2, 64'h2326, 1'b1, NO_BAD, 32'hFFFF_FFFF, 32'd0, 2,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b0, NO_RESULT};
        cases[7]  = '{16'd3, 4'd2, 64'hBEEF, 1'b1, NO_BAD, 32'd0, 32'hFFFF_FFFF, 2,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b0, NO_RESULT};
        cases[8]  = '{16'd5, 4'd2, 64'h2326, 1'b1, 1, 32'd0, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, MISMATCH_END};
        // header length lowered during the skip
        cases[9]  = '{16'd40, 4'd1, 64'h55, 1'b1, NO_BAD, 32'd1, 32'd1, 8,
                      5, CFG_HEADER_BYTES, 64'd2, 1'b0, NO_RESULT};
        // magic length lowered below the bytes already checked
        cases[10] = '{16'd0, 4'd4, 64'h1234_5678, 1'b1, NO_BAD, 32'd0, 32'd2, 8,
                      16, CFG_MAGIC_LENGTH, 64'd1, 1'b0, NO_RESULT};
        cases[11] = '{16'd1, 4'd2, 64'd0, 1'b1, NO_BAD, 32'd3, 32'd0, 8,
                      NO_MID, CFG_HEADER_BYTES, 64'd0, 1'b1, FSIZE_ZERO_END};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_CASES; i++) begin
            src_burst = (cases[i].hdr > 16'd1000);
            if (i > 0) begin
                write_reg(CFG_HEADER_BYTES, 64'(cases[i].hdr));
                write_reg(CFG_MAGIC_LENGTH, 64'(cases[i].mlen));
                write_reg(CFG_MAGIC_WORD, cases[i].mword);
            end
            run_frame(cases[i].sou, cases[i].bad_at, cases[i].ext_len, cases[i].fsize,
                      cases[i].cap, cases[i].mid_pos, cases[i].mid_idx, cases[i].mid_val);
            settle();
            if (cases[i].has_exp && last_seen !== cases[i].exp_res) begin
                n_errors++;
                $display("%0t: frame end: expected kind %0d value %h last %0d,",
                         $time, cases[i].exp_res.kind, cases[i].exp_res.value,
                         cases[i].exp_res.last,
                         " got kind %0d value %h last %0d",
                         last_seen.kind, last_seen.value, last_seen.last);
            end
        end

        beats_fed = 0;
        while (beats_fed < RANDOM_BEATS) begin
            src_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) begin
                settle();
                write_reg(CFG_HEADER_BYTES,
                          ($urandom_range(0, 9) == 0) ? 64'd54 : 64'($urandom_range(0, 6)));
                write_reg(CFG_MAGIC_LENGTH, 64'($urandom_range(0, 15)));
                write_reg(CFG_MAGIC_WORD, {$urandom, $urandom});
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 10)) begin
                    put_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    beats_fed++;
                end
            end
            ext_len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
            fsize   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4);
            bad_at  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : NO_BAD;
            mid_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : NO_MID;
            mid_idx = t_cfg_idx'($urandom_range(0, 2));
            case (mid_idx)
                CFG_MAGIC_WORD:   mid_val = {$urandom, $urandom};
                CFG_MAGIC_LENGTH: mid_val = 64'($urandom_range(0, 15));
                default:          mid_val = 64'($urandom_range(0, 8));
            endcase
            run_frame($urandom_range(0, 9) != 0, bad_at, ext_len, fsize, $urandom_range(2, 8),
                      mid_pos, mid_idx, mid_val);
        end

        settle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("lsb_stego_frame_decoder_unit_tb: clean");
        else
            $display("lsb_stego_frame_decoder_unit_tb: errors");
        $finish;
    end

endmodule
